[hdl/capstep_pkg.sv]
// ----------------------------------------------------------------------------
// capstep_pkg
// shared types, constants and helpers of the chiral active particle step
// ----------------------------------------------------------------------------
package capstep_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int NSTEP = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

    // binary angle constants, 32768 = pi
    localparam logic signed [16:0] MY_PI  = 17'sd32768;
    localparam logic signed [17:0] MY_2PI = 18'sd65536;
    localparam logic signed [15:0] QUARTER_TURN = 16'sd16384;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] HALF_TURN_Z = 34'sd2147483648;

    localparam logic [2:0] REG_ANGLE_STEP  = 3'd0;
    localparam logic [2:0] REG_ANGLE_NOISE = 3'd1;
    localparam logic [2:0] REG_POS_NOISE   = 3'd2;
    localparam logic [2:0] REG_MOBILITY    = 3'd3;
    localparam logic [2:0] REG_SELF_SPEED  = 3'd4;
    localparam logic [2:0] REG_TIME_STEP   = 3'd5;

    typedef struct packed {
        logic               grp;
        logic               last;
        logic signed [15:0] ang;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [48:0] fmx;
        logic signed [48:0] fmy;
        logic signed [36:0] nxr;
        logic signed [36:0] nyr;
    } t_carry;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [15:0] angle_step;
        logic        [15:0] angle_noise_scale;
        logic        [31:0] pos_noise_scale;
        logic        [31:0] mobility;
        logic        [31:0] self_speed;
        logic        [31:0] time_step;
    } t_cfg;

    function automatic logic signed [33:0] f_atan(input int i);
        logic signed [33:0] r;
        unique case (i)
            0:  r = 34'sd536870912;
            1:  r = 34'sd316933406;
            2:  r = 34'sd167458907;
            3:  r = 34'sd85004756;
            4:  r = 34'sd42667331;
            5:  r = 34'sd21354465;
            6:  r = 34'sd10679838;
            7:  r = 34'sd5340245;
            8:  r = 34'sd2670163;
            9:  r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > 52'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -52'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[hdl/capstep_if.sv]
// ----------------------------------------------------------------------------
// capstep_in_if / capstep_out_if
// valid/ready channels carrying particle requests and results
// ----------------------------------------------------------------------------
interface capstep_in_if;
    logic               valid;
    logic               ready;
    logic               in_group;
    logic               is_last;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [15:0] angle;
    logic signed [15:0] angle_noise;
    logic signed [15:0] noise_x;
    logic signed [15:0] noise_y;

    modport source (output valid, in_group, is_last, pos_x, pos_y, force_x, force_y,
                    angle, angle_noise, noise_x, noise_y, input ready);
    modport sink   (input valid, in_group, is_last, pos_x, pos_y, force_x, force_y,
                    angle, angle_noise, noise_x, noise_y, output ready);
endinterface

interface capstep_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] new_angle;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic               last_out;

    modport source (output valid, new_angle, vel_x, vel_y, new_pos_x, new_pos_y,
                    last_out, input ready);
    modport sink   (input valid, new_angle, vel_x, vel_y, new_pos_x, new_pos_y,
                    last_out, output ready);
endinterface

[hdl/capstep_front.sv]
// ----------------------------------------------------------------------------
// capstep_front
// input products, heading update and cordic setup (two stages)
// ----------------------------------------------------------------------------
module capstep_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  capstep_pkg::t_cfg   i_cfg,
    capstep_in_if.sink          i_in,
    output logic                o_valid,
    output capstep_pkg::t_carry o_carry,
    output capstep_pkg::t_vec   o_vec
);
    import capstep_pkg::*;

    logic               r_v1;
    logic               r_grp1;
    logic               r_last1;
    logic signed [15:0] r_ang1;
    logic signed [31:0] r_px1;
    logic signed [31:0] r_py1;
    logic signed [32:0] r_pa;
    logic signed [64:0] r_pfx;
    logic signed [64:0] r_pfy;
    logic signed [48:0] r_pnx;
    logic signed [48:0] r_pny;

    logic signed [32:0] n_pa;
    logic signed [64:0] n_pfx;
    logic signed [64:0] n_pfy;
    logic signed [48:0] n_pnx;
    logic signed [48:0] n_pny;

    logic               r_v2;
    t_carry             r_carry;
    t_vec               r_vec;
    t_carry             n_carry;
    t_vec               n_vec;
    logic signed [32:0] n_ar;
    logic signed [15:0] n_t;
    logic signed [64:0] n_fxr;
    logic signed [64:0] n_fyr;
    logic signed [48:0] n_nxr;
    logic signed [48:0] n_nyr;
    logic signed [33:0] n_z0;

    assign n_pa  = $signed({1'b0, i_cfg.angle_noise_scale}) * i_in.angle_noise;
    assign n_pfx = $signed({1'b0, i_cfg.mobility}) * i_in.force_x;
    assign n_pfy = $signed({1'b0, i_cfg.mobility}) * i_in.force_y;
    assign n_pnx = $signed({1'b0, i_cfg.pos_noise_scale}) * i_in.noise_x;
    assign n_pny = $signed({1'b0, i_cfg.pos_noise_scale}) * i_in.noise_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_in.valid;
        end
        if (i_en) begin
            r_grp1  <= i_in.in_group;
            r_last1 <= i_in.is_last;
            r_ang1  <= i_in.angle;
            r_px1   <= i_in.pos_x;
            r_py1   <= i_in.pos_y;
            r_pa    <= n_pa;
            r_pfx   <= n_pfx;
            r_pfy   <= n_pfy;
            r_pnx   <= n_pnx;
            r_pny   <= n_pny;
        end
    end

    always_comb begin
        n_ar  = (r_pa + 33'sd2048) >>> 12;
        n_t   = r_ang1 + i_cfg.angle_step + n_ar[15:0];
        n_fxr = (r_pfx + 65'sd32768) >>> 16;
        n_fyr = (r_pfy + 65'sd32768) >>> 16;
        n_nxr = (r_pnx + 49'sd2048) >>> 12;
        n_nyr = (r_pny + 49'sd2048) >>> 12;

        n_carry.grp  = r_grp1;
        n_carry.last = r_last1;
        n_carry.ang  = r_grp1 ? n_t : r_ang1;
        n_carry.px   = r_px1;
        n_carry.py   = r_py1;
        n_carry.fmx  = n_fxr[48:0];
        n_carry.fmy  = n_fyr[48:0];
        n_carry.nxr  = n_nxr[36:0];
        n_carry.nyr  = n_nyr[36:0];

        // fold headings beyond a quarter turn by a half turn
        n_z0    = $signed({{2{n_t[15]}}, n_t, 16'b0});
        n_vec.y = 34'sd0;
        if (n_t > QUARTER_TURN) begin
            n_vec.z = n_z0 - HALF_TURN_Z;
            n_vec.x = -CORDIC_GAIN;
        end else if (n_t < -QUARTER_TURN) begin
            n_vec.z = n_z0 + HALF_TURN_Z;
            n_vec.x = -CORDIC_GAIN;
        end else begin
            n_vec.z = n_z0;
            n_vec.x = CORDIC_GAIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_carry <= n_carry;
            r_vec   <= n_vec;
        end
    end

    assign i_in.ready = i_en;
    assign o_valid    = r_v2;
    assign o_carry    = r_carry;
    assign o_vec      = r_vec;

endmodule

[hdl/capstep_cordic.sv]
// ----------------------------------------------------------------------------
// capstep_cordic
// rotation cordic, one registered stage per step
// ----------------------------------------------------------------------------
module capstep_cordic (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  capstep_pkg::t_carry i_carry,
    input  capstep_pkg::t_vec   i_vec,
    output logic                o_valid,
    output capstep_pkg::t_carry o_carry,
    output capstep_pkg::t_vec   o_vec
);
    import capstep_pkg::*;

    logic   r_v     [NSTEP];
    t_carry r_carry [NSTEP];
    t_vec   r_vec   [NSTEP];

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        logic   v_in;
        t_carry c_in;
        t_vec   d_in;
        t_vec   n_vec;

        if (k == 0) begin : g_first
            assign v_in = i_valid;
            assign c_in = i_carry;
            assign d_in = i_vec;
        end else begin : g_next
            assign v_in = r_v[k-1];
            assign c_in = r_carry[k-1];
            assign d_in = r_vec[k-1];
        end

        always_comb begin
            if (d_in.z >= 34'sd0) begin
                n_vec.x = d_in.x - (d_in.y >>> k);
                n_vec.y = d_in.y + (d_in.x >>> k);
                n_vec.z = d_in.z - f_atan(k);
            end else begin
                n_vec.x = d_in.x + (d_in.y >>> k);
                n_vec.y = d_in.y - (d_in.x >>> k);
                n_vec.z = d_in.z + f_atan(k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
            if (i_en) begin
                r_carry[k] <= c_in;
                r_vec[k]   <= n_vec;
            end
        end
    end

    assign o_valid = r_v[NSTEP-1];
    assign o_carry = r_carry[NSTEP-1];
    assign o_vec   = r_vec[NSTEP-1];

endmodule

[hdl/capstep_back.sv]
// ----------------------------------------------------------------------------
// capstep_back
// velocity and position update, four stages ending in the output register
// ----------------------------------------------------------------------------
module capstep_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  capstep_pkg::t_cfg   i_cfg,
    input  logic                i_valid,
    input  capstep_pkg::t_carry i_carry,
    input  capstep_pkg::t_vec   i_vec,
    capstep_out_if.source       o_out
);
    import capstep_pkg::*;

    logic               r_v3;
    t_carry             r_c3;
    logic signed [66:0] r_scx;
    logic signed [66:0] r_scy;

    logic               r_v4;
    t_carry             r_c4;
    logic signed [31:0] r_vx4;
    logic signed [31:0] r_vy4;
    logic signed [66:0] n_sxr;
    logic signed [66:0] n_syr;
    logic signed [51:0] n_sumx;
    logic signed [51:0] n_sumy;

    logic               r_v5;
    t_carry             r_c5;
    logic signed [31:0] r_vx5;
    logic signed [31:0] r_vy5;
    logic signed [64:0] r_pdx;
    logic signed [64:0] r_pdy;

    logic               r_v6;
    logic signed [15:0] r_ang6;
    logic               r_last6;
    logic signed [31:0] r_vx6;
    logic signed [31:0] r_vy6;
    logic signed [31:0] r_qx6;
    logic signed [31:0] r_qy6;
    logic signed [64:0] n_dxr;
    logic signed [64:0] n_dyr;
    logic signed [51:0] n_qx;
    logic signed [51:0] n_qy;

    always_comb begin
        n_sxr  = (r_scx + 67'sd536870912) >>> 30;
        n_syr  = (r_scy + 67'sd536870912) >>> 30;
        n_sumx = 52'(r_c3.fmx) + 52'($signed(n_sxr[36:0]));
        n_sumy = 52'(r_c3.fmy) + 52'($signed(n_syr[36:0]));
        n_dxr  = (r_pdx + 65'sd32768) >>> 16;
        n_dyr  = (r_pdy + 65'sd32768) >>> 16;
        n_qx   = 52'(r_c5.px) + 52'($signed(n_dxr[48:0])) + 52'(r_c5.nxr);
        n_qy   = 52'(r_c5.py) + 52'($signed(n_dyr[48:0])) + 52'(r_c5.nyr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
        if (i_en) begin
            r_c3    <= i_carry;
            r_scx   <= $signed({1'b0, i_cfg.self_speed}) * i_vec.x;
            r_scy   <= $signed({1'b0, i_cfg.self_speed}) * i_vec.y;

            r_c4    <= r_c3;
            r_vx4   <= r_c3.grp ? f_sat32(n_sumx) : 32'sd0;
            r_vy4   <= r_c3.grp ? f_sat32(n_sumy) : 32'sd0;

            r_c5    <= r_c4;
            r_vx5   <= r_vx4;
            r_vy5   <= r_vy4;
            r_pdx   <= $signed({1'b0, i_cfg.time_step}) * r_vx4;
            r_pdy   <= $signed({1'b0, i_cfg.time_step}) * r_vy4;

            r_ang6  <= r_c5.ang;
            r_last6 <= r_c5.last;
            r_vx6   <= r_vx5;
            r_vy6   <= r_vy5;
            r_qx6   <= r_c5.grp ? f_sat32(n_qx) : r_c5.px;
            r_qy6   <= r_c5.grp ? f_sat32(n_qy) : r_c5.py;
        end
    end

    assign o_out.valid     = r_v6;
    assign o_out.new_angle = r_ang6;
    assign o_out.vel_x     = r_vx6;
    assign o_out.vel_y     = r_vy6;
    assign o_out.new_pos_x = r_qx6;
    assign o_out.new_pos_y = r_qy6;
    assign o_out.last_out  = r_last6;

endmodule

[hdl/chiral_active_particle_step.sv]
// ----------------------------------------------------------------------------
// chiral_active_particle_step
// one euler-maruyama update of a 2d chiral active particle per request
// ----------------------------------------------------------------------------
// usage:
//   i_in carries one particle request (position, force, heading, noise),
//   o_out carries its result; both are valid/ready channels.
//   the user writes registers over the apb port only while the block is idle;
//   the block itself does not enforce this.
// stages: two input, one per cordic step, four velocity/position.
// throughput: one request per cycle unless o_out stalls; every stage is a
//   register and the whole pipeline advances together.
// stall: when o_out holds a result that is not taken, every stage holds
//   and i_in.ready drops; nothing is lost or repeated.
// reset: pipeline valid bits clear, registers return to their reset values
//   (mobility 1.0, all others zero).
// ----------------------------------------------------------------------------
module chiral_active_particle_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    capstep_in_if.sink    i_in,
    capstep_out_if.source o_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import capstep_pkg::*;

    t_cfg   r_cfg;
    logic   w_en;
    logic   w_fv;
    t_carry w_fc;
    t_vec   w_fd;
    logic   w_cv;
    t_carry w_cc;
    t_vec   w_cd;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle_step        <= 16'sd0;
            r_cfg.angle_noise_scale <= 16'd0;
            r_cfg.pos_noise_scale   <= 32'd0;
            r_cfg.mobility          <= 32'd65536;
            r_cfg.self_speed        <= 32'd0;
            r_cfg.time_step         <= 32'd0;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_ANGLE_STEP:  r_cfg.angle_step        <= pwdata[15:0];
                REG_ANGLE_NOISE: r_cfg.angle_noise_scale <= pwdata[15:0];
                REG_POS_NOISE:   r_cfg.pos_noise_scale   <= pwdata;
                REG_MOBILITY:    r_cfg.mobility          <= pwdata;
                REG_SELF_SPEED:  r_cfg.self_speed        <= pwdata;
                REG_TIME_STEP:   r_cfg.time_step         <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_ANGLE_STEP:  prdata = {{16{r_cfg.angle_step[15]}}, r_cfg.angle_step};
            REG_ANGLE_NOISE: prdata = {16'd0, r_cfg.angle_noise_scale};
            REG_POS_NOISE:   prdata = r_cfg.pos_noise_scale;
            REG_MOBILITY:    prdata = r_cfg.mobility;
            REG_SELF_SPEED:  prdata = r_cfg.self_speed;
            REG_TIME_STEP:   prdata = r_cfg.time_step;
            default:         prdata = 32'd0;
        endcase
    end

    assign w_en = !o_out.valid || o_out.ready;

    capstep_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_valid (w_fv),
        .o_carry (w_fc),
        .o_vec   (w_fd)
    );

    capstep_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_carry (w_fc),
        .i_vec   (w_fd),
        .o_valid (w_cv),
        .o_carry (w_cc),
        .o_vec   (w_cd)
    );

    capstep_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_valid (w_cv),
        .i_carry (w_cc),
        .i_vec   (w_cd),
        .o_out   (o_out)
    );

endmodule

[hdl/capstep_checker.sv]
// ----------------------------------------------------------------------------
// capstep_checker
// port-level checks of the particle step pipeline
// ----------------------------------------------------------------------------
module capstep_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_ready_free: assert property (@(posedge i_clk)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_pready: assert property (@(posedge i_clk)
        i_pready)
        else $error("pready low");

endmodule

bind chiral_active_particle_step capstep_checker u_capstep_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_pready    (pready)
);

[test/chiral_active_particle_step_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chiral_active_particle_step_chk
// watches the particle request and result channels, computes the expected
// heading, velocity and position of every accepted request and compares them
// field by field with the results in order
// ----------------------------------------------------------------------------
module chiral_active_particle_step_chk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    capstep_in_if             i_req,
    capstep_out_if            i_res,
    input  capstep_pkg::t_cfg i_cfg,
    output int                o_fail_cnt,
    output int                o_pending
);
    import capstep_pkg::*;

    typedef struct {
        logic signed [15:0] new_angle;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic               last_out;
    } t_particle_res;

    t_particle_res expected_q[$];

    function automatic longint floor_shift(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint round_shift(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic void heading_cos_sin(input longint a16, output longint c,
                                            output longint s);
        longint z, x, y, nx;
        longint atan_q31[24] = '{536870912, 316933406, 167458907, 85004756,
            42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
            333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652,
            326, 163, 81};
        z = a16 * 65536;
        x = 652032874;
        y = 0;
        if (z > (longint'(1) <<< 30)) begin
            z -= longint'(1) <<< 31;
            x = -x;
        end else if (z < -(longint'(1) <<< 30)) begin
            z += longint'(1) <<< 31;
            x = -x;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z -= atan_q31[i];
            end else begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z += atan_q31[i];
            end
            x = nx;
        end
        c = x;
        s = y;
    endfunction

    function automatic t_particle_res advance_particle(
        input logic grp, input logic last, input longint px, input longint py,
        input longint fx, input longint fy, input longint ang, input longint an,
        input longint nx, input longint ny);
        t_particle_res r;
        longint t, c, s, vx, vy, mob, spd, dt, pn;
        r.new_angle = ang[15:0];
        r.vel_x = '0;
        r.vel_y = '0;
        r.new_pos_x = px[31:0];
        r.new_pos_y = py[31:0];
        r.last_out = last;
        if (grp) begin
            mob = longint'(i_cfg.mobility);
            spd = longint'(i_cfg.self_speed);
            dt = longint'(i_cfg.time_step);
            pn = longint'(i_cfg.pos_noise_scale);
            t = ang + longint'(i_cfg.angle_step)
                + round_shift(longint'(i_cfg.angle_noise_scale) * an, 12);
            t = t & 65535;
            if (t >= 32768) begin
                t -= 65536;
            end
            r.new_angle = t[15:0];
            heading_cos_sin(t, c, s);
            vx = clamp32(round_shift(fx * mob, 16) + round_shift(spd * c, 30));
            vy = clamp32(round_shift(fy * mob, 16) + round_shift(spd * s, 30));
            r.vel_x = vx[31:0];
            r.vel_y = vy[31:0];
            t = clamp32(px + round_shift(dt * vx, 16) + round_shift(pn * nx, 12));
            r.new_pos_x = t[31:0];
            t = clamp32(py + round_shift(dt * vy, 16) + round_shift(pn * ny, 12));
            r.new_pos_y = t[31:0];
        end
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_particle_res e;
        if (!i_rst_n) begin
            o_fail_cnt <= 0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                expected_q.push_back(advance_particle(i_req.in_group, i_req.is_last,
                    i_req.pos_x, i_req.pos_y, i_req.force_x, i_req.force_y,
                    i_req.angle, i_req.angle_noise, i_req.noise_x, i_req.noise_y));
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result");
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (e.new_angle !== i_res.new_angle ||
                        e.vel_x !== i_res.vel_x || e.vel_y !== i_res.vel_y ||
                        e.new_pos_x !== i_res.new_pos_x ||
                        e.new_pos_y !== i_res.new_pos_y ||
                        e.last_out !== i_res.last_out) begin
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                    if (e.new_angle !== i_res.new_angle)
                        $error("new_angle exp %0d got %0d", e.new_angle, i_res.new_angle);
                    if (e.vel_x !== i_res.vel_x)
                        $error("vel_x exp %0d got %0d", e.vel_x, i_res.vel_x);
                    if (e.vel_y !== i_res.vel_y)
                        $error("vel_y exp %0d got %0d", e.vel_y, i_res.vel_y);
                    if (e.new_pos_x !== i_res.new_pos_x)
                        $error("new_pos_x exp %0d got %0d", e.new_pos_x, i_res.new_pos_x);
                    if (e.new_pos_y !== i_res.new_pos_y)
                        $error("new_pos_y exp %0d got %0d", e.new_pos_y, i_res.new_pos_y);
                    if (e.last_out !== i_res.last_out)
                        $error("last_out exp %0d got %0d", e.last_out, i_res.last_out);
                end
            end
        end
    end

endmodule

[test/chiral_active_particle_step_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chiral_active_particle_step_tb
// drives particle requests and register writes through several settings,
// with random idling on both channels and long result stalls; the checker
// beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module chiral_active_particle_step_tb;
    import capstep_pkg::*;

    localparam int LATENCY = CORDIC_STEPS + 6;
    localparam int IDLE_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    t_cfg        cfg;
    int          fail_cnt;
    int          pending;
    int          src_idle_pct;
    int          snk_idle_pct;
    int          hold_cycles;
    int          idle_cnt;
    logic [15:0] corner_ang [9] = '{16'h0000, 16'h3fff, 16'h4000, 16'h4001, 16'hc000,
                                   16'hbfff, 16'h7fff, 16'h8000, 16'hffff};

    capstep_in_if  req_if ();
    capstep_out_if res_if ();

    chiral_active_particle_step DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    chiral_active_particle_step_chk u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .i_res      (res_if),
        .i_cfg      (cfg),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side idling and long hold-offs
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("[chiral_active_particle_step] ERROR");
                $finish;
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ANGLE_STEP:  cfg.angle_step = value[15:0];
            REG_ANGLE_NOISE: cfg.angle_noise_scale = value[15:0];
            REG_POS_NOISE:   cfg.pos_noise_scale = value;
            REG_MOBILITY:    cfg.mobility = value;
            REG_SELF_SPEED:  cfg.self_speed = value;
            REG_TIME_STEP:   cfg.time_step = value;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_particle(input logic grp, input logic last,
                                 input logic [31:0] px, input logic [31:0] py,
                                 input logic [31:0] fx, input logic [31:0] fy,
                                 input logic [15:0] ang, input logic [15:0] an,
                                 input logic [15:0] nx, input logic [15:0] ny);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.in_group <= grp;
        req_if.is_last <= last;
        req_if.pos_x <= px;
        req_if.pos_y <= py;
        req_if.force_x <= fx;
        req_if.force_y <= fy;
        req_if.angle <= ang;
        req_if.angle_noise <= an;
        req_if.noise_x <= nx;
        req_if.noise_y <= ny;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(99)
                                           : 32'h80000000 + $urandom_range(99);
            default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
        endcase
    endfunction

    function automatic logic [15:0] rand_noise();
        if ($urandom_range(3) == 0) begin
            return 16'($urandom);
        end
        return $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
    endfunction

    task automatic send_random();
        send_particle($urandom_range(9) != 0, $urandom_range(7) == 0,
            rand_q16(), rand_q16(), rand_q16(), rand_q16(), 16'($urandom),
            rand_noise(), rand_noise(), rand_noise());
    endtask

    task automatic random_setting(input int sel);
        case (sel)
            0: begin
                reg_write(REG_ANGLE_STEP, 32'hffff8000);
                reg_write(REG_ANGLE_NOISE, 32'h0000ffff);
                reg_write(REG_POS_NOISE, 32'hffffffff);
                reg_write(REG_MOBILITY, 32'hffffffff);
                reg_write(REG_SELF_SPEED, 32'hffffffff);
                reg_write(REG_TIME_STEP, 32'hffffffff);
            end
            1: begin
                reg_write(REG_ANGLE_STEP, 32'h00007fff);
                reg_write(REG_ANGLE_NOISE, 32'h0);
                reg_write(REG_POS_NOISE, 32'h0);
                reg_write(REG_MOBILITY, 32'h0);
                reg_write(REG_SELF_SPEED, 32'h0);
                reg_write(REG_TIME_STEP, 32'h0);
            end
            default: begin
                reg_write(REG_ANGLE_STEP, $urandom);
                reg_write(REG_ANGLE_NOISE, $urandom_range(0, 4095));
                reg_write(REG_POS_NOISE, $urandom_range(0, 32'h0001ffff));
                reg_write(REG_MOBILITY, $urandom_range(0, 32'h0003ffff));
                reg_write(REG_SELF_SPEED, $urandom_range(0, 32'h000fffff));
                reg_write(REG_TIME_STEP, $urandom_range(0, 32'h00020000));
            end
        endcase
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_cycles = 0;
        src_idle_pct = 21;
        snk_idle_pct = 76;
        req_if.valid = 1'b0;
        req_if.in_group = 1'b0;
        req_if.is_last = 1'b0;
        req_if.pos_x = '0;
        req_if.pos_y = '0;
        req_if.force_x = '0;
        req_if.force_y = '0;
        req_if.angle = '0;
        req_if.angle_noise = '0;
        req_if.noise_x = '0;
        req_if.noise_y = '0;
        res_if.ready = 1'b0;
        cfg = '{angle_step: 16'sd0, angle_noise_scale: 16'd0, pos_noise_scale: 32'd0,
                mobility: 32'd65536, self_speed: 32'd0, time_step: 32'd0};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values, then a typical setting
        send_particle(1'b1, 1'b0, 32'h00010000, 32'hffff0000, 32'h00020000,
                      32'hfffe0000, 16'h4000, 16'h1000, 16'h1000, 16'hf000);
        send_particle(1'b0, 1'b1, 32'h12345678, 32'h87654321, 32'h7fffffff,
                      32'h80000000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        wait_drained();
        reg_write(REG_ANGLE_STEP, 32'h00000100);
        reg_write(REG_ANGLE_NOISE, 32'h00000200);
        reg_write(REG_POS_NOISE, 32'h00000800);
        reg_write(REG_MOBILITY, 32'h00008000);
        reg_write(REG_SELF_SPEED, 32'h00030000);
        reg_write(REG_TIME_STEP, 32'h00001000);
        // headings around the quadrant boundaries and wrap, plus field extremes
        foreach (corner_ang[k]) begin
            send_particle(1'b1, k[0], 32'h0, 32'h0, 32'h0, 32'h0,
                          corner_ang[k], 16'h0, 16'h0, 16'h0);
        end
        wait_drained();
        random_setting(0);
        send_particle(1'b1, 1'b1, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                      32'h80000000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
        send_particle(1'b1, 1'b0, 32'h80000000, 32'h7fffffff, 32'h80000000,
                      32'h7fffffff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
        send_particle(1'b1, 1'b0, 32'hffffffff, 32'h0, 32'hffffffff, 32'h1,
                      16'hffff, 16'hffff, 16'hffff, 16'h0001);
        wait_drained();
        random_setting(1);
        send_particle(1'b1, 1'b1, 32'h00050000, 32'hfffb0000, 32'h7fffffff,
                      32'h80000000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 76 : 0;
            snk_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 21 : 0;
            for (int blk = 0; blk < 6; blk++) begin
                random_setting((blk == 5) ? phase % 2 : 2);
                if (blk == 2) begin
                    hold_cycles <= 200;
                end
                repeat (70) send_random();
                req_if.valid <= 1'b0;
                wait_drained();
            end
        end

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY * 2) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("[chiral_active_particle_step] OK");
        end else begin
            $display("[chiral_active_particle_step] ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/capstep_pkg.sv
hdl/capstep_if.sv
hdl/capstep_front.sv
hdl/capstep_cordic.sv
hdl/capstep_back.sv
hdl/chiral_active_particle_step.sv
hdl/capstep_checker.sv
test/chiral_active_particle_step_chk.sv
test/chiral_active_particle_step_tb.sv
